>>> hdl/lpdi_pkg.sv
package lpdi_pkg;

	localparam int unsigned KEY_W      = 64;
	localparam int unsigned PROBE_W    = 7;
	localparam int unsigned SLOT_OUT_W = 12;
	localparam int unsigned PROBE_CAP  = 64;

	typedef enum logic [1:0] {
		STATUS_NEW  = 2'd0,
		STATUS_DUP  = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_PROBE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// clamp the probe limit register to 1..64
	function automatic logic [PROBE_W-1:0] eff_limit(input logic [PROBE_W-1:0] mp);
		logic [PROBE_W-1:0] r;
		r = mp;
		if (mp == '0)
			r = PROBE_W'(1);
		else if (mp > PROBE_W'(PROBE_CAP))
			r = PROBE_W'(PROBE_CAP);
		return r;
	endfunction

endpackage

>>> hdl/linear_probe_dedup_insert.sv
// Deduplicating hash insert by linear probing over a single-port-write, one-read key RAM.
// After reset the block sweeps the table to zero, one slot a cycle; in_ready stays low until
// the sweep ends. Each item then probes n slots, n running from 1 to max_probes clamped to 1..64.
// The home slot is the low key bits when TABLE_SLOTS is a power of two; otherwise the remainder is
// built 16 key bits at a time by a reciprocal multiply and a correcting subtract. The probe
// loop reads one slot per cycle from the RAM, whose read data is registered. A finished result
// sits in an output register, so a new item is accepted while it waits to be taken. Slot outputs
// carry the low 12 bits of the slot number.
module linear_probe_dedup_insert #(
	parameter int unsigned TABLE_SLOTS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpdi_pkg::PROBE_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpdi_pkg::KEY_W-1:0]        key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [lpdi_pkg::SLOT_OUT_W-1:0]   slot,
	output logic [lpdi_pkg::PROBE_W-1:0]      probes_used
);

	localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int unsigned PROBE_W = lpdi_pkg::PROBE_W;

	lpdi_pkg::state_t            state_q;
	logic [PROBE_W-1:0]          max_probes_q;
	logic [PROBE_W-1:0]          limit_q;
	logic [lpdi_pkg::KEY_W-1:0]  key_q;
	logic [SLOT_W-1:0]           clr_addr_q;
	logic [SLOT_W-1:0]           rd_addr_q;

	logic                        chk_valid_s1;
	logic [SLOT_W-1:0]           chk_addr_s1;
	logic [PROBE_W-1:0]          chk_cnt_s1;

	lpdi_pkg::status_t           res_status_q;
	logic [SLOT_W-1:0]           res_slot_q;
	logic [PROBE_W-1:0]          res_cnt_q;

	logic                        out_valid_q;
	lpdi_pkg::status_t           out_status_q;
	logic [lpdi_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic [PROBE_W-1:0]          out_cnt_q;

	logic                        accept;
	logic                        home_done;
	logic [SLOT_W-1:0]           home;
	logic [lpdi_pkg::KEY_W-1:0]  rd_data;
	logic                        hit_empty;
	logic                        hit_dup;
	logic                        stop;
	logic                        rd_en;
	logic                        wr_en;
	logic [SLOT_W-1:0]           wr_addr;
	logic [lpdi_pkg::KEY_W-1:0]  wr_data;
	logic [SLOT_W-1:0]           rd_addr_inc;

	assign in_ready    = (state_q == lpdi_pkg::ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slot        = out_slot_q;
	assign probes_used = out_cnt_q;

	assign rd_addr_inc = (rd_addr_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : rd_addr_q + SLOT_W'(1);

	// empty is checked first so a zero key lands on the first empty slot
	assign hit_empty = (rd_data == '0);
	assign hit_dup   = (rd_data == key_q);
	assign stop      = hit_empty || hit_dup || (chk_cnt_s1 == limit_q);

	assign rd_en = (state_q == lpdi_pkg::ST_PROBE) && !(chk_valid_s1 && stop);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_addr_s1;
		wr_data = key_q;
		if (state_q == lpdi_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (state_q == lpdi_pkg::ST_PROBE && chk_valid_s1 && hit_empty) begin
			wr_en = 1'b1;
		end
	end

	lpdi_home #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (key),
		.done  (home_done),
		.home  (home)
	);

	lpdi_key_ram #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_probes_q <= PROBE_W'(lpdi_pkg::PROBE_CAP);
		end else if (cfg_we) begin
			max_probes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lpdi_pkg::ST_CLEAR;
			clr_addr_q   <= '0;
			chk_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// a result loaded in the done state takes over from the one leaving
			if (out_valid_q && out_ready && state_q != lpdi_pkg::ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				lpdi_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + SLOT_W'(1);
					if (clr_addr_q == SLOT_W'(TABLE_SLOTS - 1))
						state_q <= lpdi_pkg::ST_IDLE;
				end
				lpdi_pkg::ST_IDLE: begin
					if (accept)
						state_q <= lpdi_pkg::ST_HASH;
				end
				lpdi_pkg::ST_HASH: begin
					chk_valid_s1 <= 1'b0;
					if (home_done)
						state_q <= lpdi_pkg::ST_PROBE;
				end
				lpdi_pkg::ST_PROBE: begin
					if (chk_valid_s1 && stop) begin
						chk_valid_s1 <= 1'b0;
						state_q      <= lpdi_pkg::ST_DONE;
					end else begin
						chk_valid_s1 <= 1'b1;
					end
				end
				lpdi_pkg::ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= lpdi_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lpdi_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= key;
			limit_q <= lpdi_pkg::eff_limit(max_probes_q);
		end
		if (state_q == lpdi_pkg::ST_HASH && home_done)
			rd_addr_q <= home;
		// issue the next read while the previous slot is compared
		if (rd_en) begin
			rd_addr_q   <= rd_addr_inc;
			chk_addr_s1 <= rd_addr_q;
			chk_cnt_s1  <= chk_valid_s1 ? chk_cnt_s1 + PROBE_W'(1) : PROBE_W'(1);
		end
		if (state_q == lpdi_pkg::ST_PROBE && chk_valid_s1 && stop) begin
			res_slot_q <= chk_addr_s1;
			res_cnt_q  <= chk_cnt_s1;
			if (hit_empty)
				res_status_q <= lpdi_pkg::STATUS_NEW;
			else if (hit_dup)
				res_status_q <= lpdi_pkg::STATUS_DUP;
			else
				res_status_q <= lpdi_pkg::STATUS_FULL;
		end
		if (state_q == lpdi_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			out_status_q <= res_status_q;
			out_slot_q   <= lpdi_pkg::SLOT_OUT_W'(res_slot_q);
			out_cnt_q    <= res_cnt_q;
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_hash: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == lpdi_pkg::ST_HASH)
		else $error("accepted item did not start hashing");

	a_home_only_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		home_done |-> state_q == lpdi_pkg::ST_HASH)
		else $error("home slot finished outside hashing");

	a_probe_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chk_valid_s1 |-> (chk_cnt_s1 != '0) && (chk_cnt_s1 <= limit_q))
		else $error("probe count outside limit");

	a_write_only_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != lpdi_pkg::ST_CLEAR) |-> chk_valid_s1 && (rd_data == '0))
		else $error("key written to an occupied slot");

	a_result_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_cnt_q >= PROBE_W'(1)) && (out_cnt_q <= PROBE_W'(lpdi_pkg::PROBE_CAP)))
		else $error("probes_used out of range");
`endif

endmodule

>>> hdl/lpdi_home.sv
module lpdi_home #(
	parameter int unsigned TABLE_SLOTS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lpdi_pkg::KEY_W-1:0]     key,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] home
);

	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);

	logic              done_q;
	logic [SLOT_W-1:0] rem_q;

	assign done = done_q;
	assign home = rem_q;

	generate
		if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[SLOT_W-1:0];
				end
			end
		end else begin : g_recip
			// remainder built 16 key bits at a time from the top: each step takes
			// v = rem * 2^16 + chunk, estimates v / TABLE_SLOTS by a reciprocal
			// multiply (low by at most one) and fixes it with one compare and subtract
			localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
			localparam logic [31:0] DIVISOR = 32'(TABLE_SLOTS);

			logic                       busy_q;
			logic [2:0]                 phase_q;
			logic [1:0]                 chunk_q;
			logic [lpdi_pkg::KEY_W-1:0] key_q;
			logic [31:0]                v_q;
			logic [31:0]                quot_q;
			logic [SLOT_W:0]            part_q;
			logic [31:0]                v_nxt;
			logic [31:0]                quot_nxt;
			logic [31:0]                back;
			logic                       last_step;

			assign v_nxt     = 32'({rem_q, key_q[lpdi_pkg::KEY_W-1 -: 16]});
			assign quot_nxt  = 32'((64'(v_nxt) * 64'(RECIP)) >> 32);
			assign back      = quot_q * DIVISOR;
			assign last_step = busy_q && phase_q[2] && (chunk_q == 2'd3);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
					phase_q <= 3'b001;
					chunk_q <= '0;
				end else begin
					done_q <= last_step;
					if (start) begin
						busy_q  <= 1'b1;
						phase_q <= 3'b001;
						chunk_q <= '0;
					end else if (busy_q) begin
						phase_q <= {phase_q[1:0], phase_q[2]};
						if (phase_q[2]) begin
							chunk_q <= chunk_q + 2'd1;
							if (last_step)
								busy_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					rem_q <= '0;
				end else if (busy_q) begin
					if (phase_q[0]) begin
						v_q    <= v_nxt;
						quot_q <= quot_nxt;
						key_q  <= key_q << 16;
					end
					// estimate is short by at most one, so this is below twice the size
					if (phase_q[1])
						part_q <= (SLOT_W + 1)'(v_q - back);
					if (phase_q[2]) begin
						if (part_q >= (SLOT_W + 1)'(TABLE_SLOTS))
							rem_q <= SLOT_W'(part_q - (SLOT_W + 1)'(TABLE_SLOTS));
						else
							rem_q <= SLOT_W'(part_q);
					end
				end
			end
		end
	endgenerate

endmodule

>>> hdl/lpdi_key_ram.sv
module lpdi_key_ram #(
	parameter int unsigned TABLE_SLOTS = 4096
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
	input  logic [lpdi_pkg::KEY_W-1:0]     wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	output logic [lpdi_pkg::KEY_W-1:0]     rd_data
);

	logic [lpdi_pkg::KEY_W-1:0] mem [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
